FILE: rtl/core/chs_pkg.sv
package chs_pkg;

   localparam int KEY_W    = 31;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam int BUCKET_W = 4;

   // The bucket count is a power of two, so a key's bucket is its low bits.
   localparam int BUCKETS  = 16;

   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_CHANGED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_LOOKUP
   } op_type;

   // Output of the front part: a classified request.
   typedef struct packed {
      op_type            op;
      logic [KEY_W-1:0]  key;
   } cmd_type;

   // Result item as a packed struct.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [BUCKET_W-1:0] bucket;
   } rsp_type;

endpackage

FILE: rtl/core/chs_front.sv
module chs_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [chs_pkg::ACTION_W-1:0]   req_action,
   input  logic [chs_pkg::KEY_W-1:0]      req_key,
   output logic                           cmd_valid,
   input  logic                           cmd_pop,
   output chs_pkg::cmd_type               cmd_data
);

   // Two-entry queue between the front and back parts.
   chs_pkg::cmd_type q_ff [2];
   logic             rd_ff, rd_in;
   logic             wr_ff, wr_in;
   logic [1:0]       cnt_ff, cnt_in;
   chs_pkg::cmd_type cls;
   logic             push;

   always_comb begin
      cls.key = req_key;
      unique case (req_action)
         chs_pkg::ACT_INSERT: cls.op = chs_pkg::OP_INSERT;
         chs_pkg::ACT_DELETE: cls.op = chs_pkg::OP_DELETE;
         default:             cls.op = chs_pkg::OP_LOOKUP;
      endcase
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      rd_in  = rd_ff ^ (cmd_pop && cmd_valid);
      wr_in  = wr_ff ^ push;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop && cmd_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

FILE: rtl/core/chs_back.sv
module chs_back #(
   parameter int POOL_NODES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  chs_pkg::cmd_type cmd_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output chs_pkg::rsp_type rsp_data
);

   localparam int BW = chs_pkg::BUCKET_W;
   localparam int NW = $clog2(POOL_NODES + 1);
   localparam int IW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

   typedef enum logic [2:0] {
      S_IDLE, S_HEAD, S_READ, S_CMP, S_ALLOC, S_LINK, S_OUT
   } state_type;

   logic [NW-1:0]          head_mem [chs_pkg::BUCKETS];
   logic [chs_pkg::KEY_W-1:0] key_mem [POOL_NODES];
   logic [NW-1:0]          next_mem [POOL_NODES];
   logic [POOL_NODES-1:0]  used_ff;
   logic [chs_pkg::BUCKETS-1:0] hvalid_ff;

   state_type              st_ff;
   chs_pkg::cmd_type       cmd_ff;
   logic [BW-1:0]          b_ff;
   logic [NW-1:0]          cur_ff, prev_ff, hit_ff;
   logic [chs_pkg::KEY_W-1:0] rkey_ff;
   logic [NW-1:0]          rnext_ff;
   logic [NW-1:0]          steps_ff;
   logic [NW-1:0]          alloc_ff;
   logic                   found_ff;
   chs_pkg::rsp_type       res_ff, res_in;
   chs_pkg::rsp_type       out_ff;
   logic                   out_v_ff;
   logic [BW-1:0]          b_in;
   logic [NW-1:0]          free_idx;
   logic                   nul_ok;

   // Bucket is key mod BUCKETS, which for a power of two is the low bits.
   assign b_in = cmd_data.key[BW-1:0];

   // Lowest free node; priority encoder over the in-use bits.
   always_comb begin
      free_idx = NIL;
      for (int i = POOL_NODES - 1; i >= 0; i--) begin
         if (!used_ff[i]) free_idx = NW'(i);
      end
   end

   always_comb begin
      res_in.found  = found_ff;
      res_in.bucket = b_ff;
      res_in.status = chs_pkg::ST_NOCHANGE;
      if (cmd_ff.op == chs_pkg::OP_INSERT && !found_ff) begin
         res_in.status = (alloc_ff >= NIL) ? chs_pkg::ST_FULL : chs_pkg::ST_CHANGED;
      end else if (cmd_ff.op == chs_pkg::OP_DELETE && found_ff) begin
         res_in.status = chs_pkg::ST_CHANGED;
      end
   end

   assign nul_ok    = 1'b1;
   assign cmd_pop   = (st_ff == S_IDLE) && cmd_valid && nul_ok;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         used_ff   <= '0;
         hvalid_ff <= '0;
         out_v_ff  <= 1'b0;
      end else begin
         // The output register is loaded only once the previous item has left it.
         if (st_ff == S_OUT && (!out_v_ff || !rsp_stall)) begin
            out_v_ff <= 1'b1;
            out_ff   <= res_ff;
         end else if (out_v_ff && !rsp_stall) begin
            out_v_ff <= 1'b0;
         end
         unique case (st_ff)
            S_IDLE: begin
               if (cmd_pop) begin
                  cmd_ff   <= cmd_data;
                  b_ff     <= b_in;
                  st_ff    <= S_HEAD;
               end
            end
            S_HEAD: begin
               cur_ff   <= hvalid_ff[b_ff] ? head_mem[b_ff] : NIL;
               prev_ff  <= NIL;
               steps_ff <= '0;
               alloc_ff <= free_idx;
               st_ff    <= S_READ;
            end
            S_READ: begin
               if (cur_ff >= NIL || steps_ff >= NW'(POOL_NODES)) begin
                  found_ff <= 1'b0;
                  hit_ff   <= NIL;
                  st_ff    <= S_ALLOC;
               end else begin
                  rkey_ff  <= key_mem[cur_ff[IW-1:0]];
                  rnext_ff <= next_mem[cur_ff[IW-1:0]];
                  st_ff    <= S_CMP;
               end
            end
            S_CMP: begin
               if (rkey_ff == cmd_ff.key) begin
                  found_ff <= 1'b1;
                  hit_ff   <= cur_ff;
                  st_ff    <= S_ALLOC;
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= rnext_ff;
                  steps_ff <= steps_ff + NW'(1);
                  st_ff    <= S_READ;
               end
            end
            S_ALLOC: begin
               res_ff <= res_in;
               if (cmd_ff.op == chs_pkg::OP_INSERT && !found_ff) begin
                  if (alloc_ff < NIL) begin
                     used_ff[alloc_ff[IW-1:0]] <= 1'b1;
                     key_mem[alloc_ff[IW-1:0]] <= cmd_ff.key;
                     next_mem[alloc_ff[IW-1:0]] <= NIL;
                     if (prev_ff >= NIL) begin
                        head_mem[b_ff]  <= alloc_ff;
                        hvalid_ff[b_ff] <= 1'b1;
                     end
                  end
               end else if (cmd_ff.op == chs_pkg::OP_DELETE && found_ff) begin
                  used_ff[hit_ff[IW-1:0]] <= 1'b0;
                  if (prev_ff < NIL) begin
                     next_mem[prev_ff[IW-1:0]] <= rnext_ff;
                  end else begin
                     head_mem[b_ff]  <= rnext_ff;
                     hvalid_ff[b_ff] <= 1'b1;
                  end
               end
               st_ff <= S_LINK;
            end
            S_LINK: begin
               // A new node behind an existing tail is linked in the cycle after S_ALLOC.
               if (cmd_ff.op == chs_pkg::OP_INSERT && !found_ff && alloc_ff < NIL
                   && prev_ff < NIL) begin
                  next_mem[prev_ff[IW-1:0]] <= alloc_ff;
               end
               st_ff <= S_OUT;
            end
            S_OUT: begin
               if (!out_v_ff || !rsp_stall) begin
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/chained_hash_set_unit.sv
// Channel   Direction  Ports
// req       in         req_valid, req_stall, req_action, req_key
// rsp       out        rsp_valid, rsp_stall, rsp_status, rsp_found, rsp_bucket
//
// The back part steps S_IDLE, S_HEAD, then S_READ and S_CMP per chain node
// visited (a found key ends at S_CMP), then S_ALLOC, S_LINK and S_OUT; the
// chain walk (one node memory read, one key compare per node) sets its length.
// Reset clears the bucket heads' valid bits and the node in-use bits at once.
// A two-item queue lets the front keep taking items while the back works.
// A held result stalls only the back; the front stalls when the queue is full.
module chained_hash_set_unit #(
   parameter int POOL_NODES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [chs_pkg::ACTION_W-1:0]  req_action,
   input  logic [chs_pkg::KEY_W-1:0]     req_key,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [chs_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [chs_pkg::BUCKET_W-1:0]  rsp_bucket
);

   logic             cmd_valid, cmd_pop;
   chs_pkg::cmd_type cmd_data;
   chs_pkg::rsp_type rsp_data;

   chs_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_action, .req_key,
      .cmd_valid, .cmd_pop, .cmd_data
   );

   chs_back #(.POOL_NODES(POOL_NODES)) u_back (
      .clock, .reset, .cmd_valid, .cmd_pop, .cmd_data,
      .rsp_valid, .rsp_stall, .rsp_data
   );

   assign rsp_status = rsp_data.status;
   assign rsp_found  = rsp_data.found;
   assign rsp_bucket = rsp_data.bucket;

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == chs_pkg::ST_CHANGED
                     || rsp_status == chs_pkg::ST_NOCHANGE
                     || rsp_status == chs_pkg::ST_FULL)) else $error("bad status");
   a_full_notfound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == chs_pkg::ST_FULL) |-> !rsp_found)
      else $error("pool full with found key");
   a_pop_needs_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop from empty queue");

endmodule
